// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication within the same cycle
`define ATC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// Implication into the next cycle
`define ATC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define ATC_ASSERT_IMPL(lbl, pre, post, msg)
`define ATC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- hw/rtl/atc_pkg.sv -----
// Shared widths, status codes and types for the table header checker.
// No dependencies.
package atc_pkg;

  localparam int unsigned DATA_W                = 32;
  localparam int unsigned BYTE_W                = 8;
  localparam int unsigned LANES                 = DATA_W / BYTE_W;
  localparam int unsigned LANE_IDX_W            = $clog2(LANES);
  localparam int unsigned LANE_CNT_W            = $clog2(LANES) + 1;
  localparam int unsigned STATUS_W              = 2;
  localparam int unsigned LEN_OUT_W             = 20;
  localparam int unsigned MIN_TABLE_LEN         = 36;
  localparam int unsigned LENGTH_LIMIT_LOG2_DEF = 20;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_VALID        = 2'd0,
    STATUS_SIG_MISMATCH = 2'd1,
    STATUS_LEN_RANGE    = 2'd2,
    STATUS_CHECKSUM     = 2'd3
  } check_status_e;

  // Result of the lane merge
  typedef struct packed {
    logic [BYTE_W-1:0] sum;
    logic              zero;
  } merge_t;

endpackage

// ----- hw/rtl/atc_ifs.sv -----
// Valid/ready channels of the table header checker: request, result, config.
// Depends on atc_pkg.
interface atc_req_if import atc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface atc_res_if import atc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  check_status;
  logic [LEN_OUT_W-1:0] table_length;
  modport source (output valid, output check_status, output table_length, input ready);
  modport sink   (input valid, input check_status, input table_length, output ready);
endinterface

interface atc_cfg_if import atc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/atc_byte_lane.sv -----
// One byte lane: passes its byte on only when it lies inside the table.
// Depends on atc_pkg.
module atc_byte_lane import atc_pkg::*; (
  input  logic [BYTE_W-1:0]     byte_i,
  input  logic [LANE_IDX_W-1:0] lane_idx_i,
  input  logic [LANE_CNT_W-1:0] count_i,
  output logic [BYTE_W-1:0]     byte_o
);

  // Drop bytes at or beyond the count of live bytes in this word
  assign byte_o = (LANE_CNT_W'(lane_idx_i) < count_i) ? byte_i : '0;

endmodule

// ----- hw/rtl/atc_sum_merge.sv -----
// Merge stage: adds the lane bytes to the running sum modulo 256.
// Depends on atc_pkg.
module atc_sum_merge import atc_pkg::*; (
  input  logic [BYTE_W-1:0]            base_i,
  input  logic [LANES-1:0][BYTE_W-1:0] lane_bytes_i,
  output merge_t                       merge_o
);

  logic [BYTE_W-1:0] pair_lo;
  logic [BYTE_W-1:0] pair_hi;
  logic [BYTE_W-1:0] total;

  // Sum the lanes as a small tree, wrapping at eight bits
  always_comb begin
    pair_lo = base_i + lane_bytes_i[0] + lane_bytes_i[1];
    pair_hi = lane_bytes_i[2] + lane_bytes_i[3];
    total   = pair_lo + pair_hi;
  end

  assign merge_o.sum  = total;
  assign merge_o.zero = (total == '0);

endmodule

// ----- hw/rtl/acpi_table_header_checker.sv -----
// Table header and checksum checker, four byte lanes per 32-bit word.
// Throughput: one word per cycle, set by the four-lane adder and remaining-count path.
// A result is registered and offered in the cycle after the word that ends or fails the table.
// A result held off by the sink stalls the next word; taking it frees the input that cycle.
// Reset (rst_ni low, asynchronous): expects word 0 of a table, no result pending,
// expected signature cleared to zero (any signature accepted).
`include "assert_macros.svh"

module acpi_table_header_checker import atc_pkg::*; #(
  parameter int unsigned LENGTH_LIMIT_LOG2 = LENGTH_LIMIT_LOG2_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atc_req_if.sink     req_i,
  atc_res_if.source   res_o,
  atc_cfg_if.sink     cfg_i
);

  localparam int unsigned LW = LENGTH_LIMIT_LOG2;

  typedef enum logic [1:0] {
    PH_SIG,
    PH_LEN,
    PH_BODY
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [BYTE_W-1:0]          sum_q, sum_d;
  logic [LW-1:0]              held_q, held_d;
  logic [LW-1:0]              rem_q, rem_d;
  logic [DATA_W-1:0]          sig_q;
  logic                       out_valid_q;
  check_status_e              out_status_q;
  logic [LEN_OUT_W-1:0]       out_len_q;

  logic                       in_ready;
  logic                       accept;
  logic [DATA_W-1:0]          word;
  logic                       sig_bad;
  logic                       len_ok;
  logic                       body_last;
  logic [LANE_CNT_W-1:0]      lane_count;
  logic [BYTE_W-1:0]          base_sum;
  logic [LANES-1:0][BYTE_W-1:0] lane_bytes;
  merge_t                     merge;
  logic                       res_fire;
  check_status_e              res_status;
  logic [LEN_OUT_W-1:0]       res_len;
  logic [31:0]                held_ext;

  // Handshakes: take a word whenever the result register is free or draining
  assign in_ready    = !out_valid_q || res_o.ready;
  assign accept      = req_i.valid && in_ready;
  assign req_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;
  assign word        = req_i.data_word;

  // Header checks
  assign sig_bad   = (sig_q != '0) && (sig_q != word);
  assign len_ok    = (word >= DATA_W'(MIN_TABLE_LEN)) &&
                     ({1'b0, word} < (33'd1 << LW));
  assign body_last = (rem_q <= LW'(4));

  // Live bytes in this word: all four except in the last word of the body
  always_comb begin
    if (phase_q == PH_BODY && body_last) begin
      lane_count = rem_q[LANE_CNT_W-1:0];
    end else begin
      lane_count = LANE_CNT_W'(LANES);
    end
  end

  assign base_sum = (phase_q == PH_SIG) ? '0 : sum_q;

  // Byte lanes
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    atc_byte_lane u_lane (
      .byte_i     (word[k*BYTE_W +: BYTE_W]),
      .lane_idx_i (LANE_IDX_W'(k)),
      .count_i    (lane_count),
      .byte_o     (lane_bytes[k])
    );
  end

  atc_sum_merge u_merge (
    .base_i       (base_sum),
    .lane_bytes_i (lane_bytes),
    .merge_o      (merge)
  );

  assign held_ext = 32'(held_q);

  // Advance the table walk
  always_comb begin
    phase_d    = phase_q;
    sum_d      = sum_q;
    held_d     = held_q;
    rem_d      = rem_q;
    res_fire   = 1'b0;
    res_status = STATUS_VALID;
    res_len    = '0;
    if (accept) begin
      case (phase_q)
        PH_SIG: begin
          if (sig_bad) begin
            res_fire   = 1'b1;
            res_status = STATUS_SIG_MISMATCH;
          end else begin
            sum_d   = merge.sum;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if (!len_ok) begin
            res_fire   = 1'b1;
            res_status = STATUS_LEN_RANGE;
            sum_d      = '0;
            phase_d    = PH_SIG;
          end else begin
            held_d  = word[LW-1:0];
            rem_d   = word[LW-1:0] - LW'(8);
            sum_d   = merge.sum;
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_last) begin
            res_fire   = 1'b1;
            res_status = merge.zero ? STATUS_VALID : STATUS_CHECKSUM;
            res_len    = held_ext[LEN_OUT_W-1:0];
            sum_d      = '0;
            held_d     = '0;
            phase_d    = PH_SIG;
          end else begin
            rem_d = rem_q - LW'(4);
            sum_d = merge.sum;
          end
        end
        default: begin
          phase_d = PH_SIG;
        end
      endcase
    end
  end

  // Hold walk state and the expected signature
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      sum_q   <= '0;
      held_q  <= '0;
      rem_q   <= '0;
      sig_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      held_q  <= held_d;
      rem_q   <= rem_d;
      if (cfg_i.valid) begin
        sig_q <= cfg_i.data;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_status_q <= res_status;
      out_len_q    <= res_len;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.check_status = out_status_q;
  assign res_o.table_length = out_len_q;

  // Checks
  `ATC_ASSERT_IMPL(a_fail_len_zero,
    out_valid_q && (out_status_q == STATUS_SIG_MISMATCH || out_status_q == STATUS_LEN_RANGE),
    out_len_q == '0, "header failure must report zero length")
  `ATC_ASSERT_IMPL(a_sum_len_min,
    out_valid_q && (out_status_q == STATUS_VALID || out_status_q == STATUS_CHECKSUM),
    out_len_q >= LEN_OUT_W'(MIN_TABLE_LEN) || LW > LEN_OUT_W,
    "checksum result below minimum table length")
  `ATC_ASSERT_NEXT(a_restart_after_result, res_fire,
    phase_q == PH_SIG && sum_q == '0, "walk did not restart after a result")

endmodule
